[hw/rtl/dtp_pkg.sv]
// Types and constants shared by the duration text parser modules.
package dtp_pkg;

   // width of the seconds field of a result word
   localparam int SECONDS_W = 32;

   // unit word store: seven letters at most, length held in three bits
   localparam int UNIT_DEPTH = 7;
   localparam int UNIT_LEN_W = 3;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_string;
   } dtp_req_type;

   typedef struct packed {
      logic                 status;
      logic [SECONDS_W-1:0] seconds;
   } dtp_rsp_type;

   typedef enum logic [1:0] {
      PH_BETWEEN,
      PH_NUMBER,
      PH_AFTER_NUM,
      PH_UNIT
   } dtp_phase_type;

   typedef enum logic [1:0] {
      UNIT_NONE,
      UNIT_SEC,
      UNIT_MIN,
      UNIT_HOUR
   } dtp_unit_type;

   // one word handed from the input register to the parser
   typedef struct packed {
      logic        fire;
      dtp_req_type word;
   } dtp_step_type;

   // result of an end marker, produced in the cycle the marker is taken
   typedef struct packed {
      logic        done;
      dtp_rsp_type rsp;
   } dtp_result_type;

endpackage

[hw/rtl/dtp_unit_match.sv]
// Unit word recogniser: maps the stored lowercase letters to a unit code.
module dtp_unit_match (
   input  logic [7:0]                      unit_chars [dtp_pkg::UNIT_DEPTH],
   input  logic [dtp_pkg::UNIT_LEN_W-1:0]  unit_len,
   output dtp_pkg::dtp_unit_type           unit_code
);
   import dtp_pkg::*;

   localparam int TOP = 8 * UNIT_DEPTH;

   logic [TOP-1:0] word;

   // pack the letters, first letter in the top byte
   always_comb begin
      for (int i = 0; i < UNIT_DEPTH; i++) begin
         word[8*(UNIT_DEPTH-1-i) +: 8] = unit_chars[i];
      end
   end

   // compare the leading letters against each spelling of the given length
   always_comb begin
      unit_code = UNIT_NONE;
      unique case (unit_len)
         3'd1: begin
            if (word[TOP-1 -: 8] == "h") unit_code = UNIT_HOUR;
            else if (word[TOP-1 -: 8] == "m") unit_code = UNIT_MIN;
            else if (word[TOP-1 -: 8] == "s") unit_code = UNIT_SEC;
         end
         3'd2: begin
            if (word[TOP-1 -: 16] == "hr") unit_code = UNIT_HOUR;
         end
         3'd3: begin
            if (word[TOP-1 -: 24] == "hrs") unit_code = UNIT_HOUR;
            else if (word[TOP-1 -: 24] == "min") unit_code = UNIT_MIN;
            else if (word[TOP-1 -: 24] == "sec") unit_code = UNIT_SEC;
         end
         3'd4: begin
            if (word[TOP-1 -: 32] == "hour") unit_code = UNIT_HOUR;
            else if (word[TOP-1 -: 32] == "mins") unit_code = UNIT_MIN;
            else if (word[TOP-1 -: 32] == "secs") unit_code = UNIT_SEC;
         end
         3'd5: begin
            if (word[TOP-1 -: 40] == "hours") unit_code = UNIT_HOUR;
         end
         3'd6: begin
            if (word[TOP-1 -: 48] == "minute") unit_code = UNIT_MIN;
            else if (word[TOP-1 -: 48] == "second") unit_code = UNIT_SEC;
         end
         3'd7: begin
            if (word[TOP-1 -: 56] == "minutes") unit_code = UNIT_MIN;
            else if (word[TOP-1 -: 56] == "seconds") unit_code = UNIT_SEC;
         end
         default: begin
            unit_code = UNIT_NONE;
         end
      endcase
   end

endmodule

[hw/rtl/dtp_parse_core.sv]
// Parser state, digit accumulation, unit totals and end-of-string result.
module dtp_parse_core #(
   parameter int TOTAL_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtp_pkg::dtp_step_type   step,
   output dtp_pkg::dtp_result_type result
);
   import dtp_pkg::*;

   localparam int TB = TOTAL_BITS;
   localparam int DW = TOTAL_BITS + 4;   // number times ten plus a digit
   localparam int PW = TOTAL_BITS + 12;  // number times 3600
   localparam int SW = PW + 4;           // scaled value times ten plus a digit

   dtp_phase_type phase_ff, phase_in;
   logic [TB-1:0] num_ff, num_in;
   logic [PW-1:0] n60_ff, n60_in;
   logic [PW-1:0] n3600_ff, n3600_in;
   logic [TB-1:0] total_ff, total_in;
   logic [7:0]    chars_ff [UNIT_DEPTH];
   logic [UNIT_LEN_W-1:0] len_ff, len_in;
   logic          first_ff, first_in;
   logic          found_ff, found_in;
   logic          err_ff, err_in;

   logic                  chars_we;
   logic [UNIT_LEN_W-1:0] chars_idx;

   logic [7:0] ch, lower;
   logic       eos, ev_char, ev_eos;
   logic       is_digit, is_alpha, is_blank;
   logic [3:0] digit;

   logic [TB-1:0] num_base;
   logic [PW-1:0] n60_base, n3600_base;
   logic [DW-1:0] nb, dig_dw, num_wide;
   logic [SW-1:0] s60b, s3600b, d_ext, n60_wide, n3600_wide;
   logic          digit_ovf;

   dtp_unit_type  unit_code;
   logic [PW-1:0] prod;
   logic [TB:0]   sum;
   logic          unit_fail;

   logic          bare_end, unit_end, final_err;
   logic [TB-1:0] total_after;
   logic [SECONDS_W-1:0] sec_word;

   // decode the word
   assign ch       = step.word.ch;
   assign eos      = step.word.end_of_string;
   assign lower    = ch | CASE_BIT;
   assign ev_eos   = step.fire && eos;
   assign ev_char  = step.fire && !eos && !err_ff;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_alpha = (lower >= CH_LOW_A) && (lower <= CH_LOW_Z);
   assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
   assign digit    = ch[3:0];

   // a fresh number starts from zero; only a running number keeps its value
   assign num_base   = (phase_ff == PH_NUMBER) ? num_ff   : '0;
   assign n60_base   = (phase_ff == PH_NUMBER) ? n60_ff   : '0;
   assign n3600_base = (phase_ff == PH_NUMBER) ? n3600_ff : '0;

   // number times ten plus digit, with overflow above the total range
   assign nb        = {4'b0000, num_base};
   assign dig_dw    = {{(DW-4){1'b0}}, digit};
   assign num_wide  = (nb << 3) + (nb << 1) + dig_dw;
   assign digit_ovf = |num_wide[DW-1:TB];

   // keep the number pre-scaled by 60 and 3600 so a unit needs no multiplier
   assign s60b       = {4'b0000, n60_base};
   assign s3600b     = {4'b0000, n3600_base};
   assign d_ext      = {{(SW-4){1'b0}}, digit};
   assign n60_wide   = (s60b << 3) + (s60b << 1) + (d_ext << 6) - (d_ext << 2);
   assign n3600_wide = (s3600b << 3) + (s3600b << 1)
                     + (d_ext << 12) - (d_ext << 9) + (d_ext << 4);

   dtp_unit_match u_unit_match (
      .unit_chars (chars_ff),
      .unit_len   (len_ff),
      .unit_code  (unit_code)
   );

   // select the scaled number for the unit and add it to the total
   always_comb begin
      unique case (unit_code)
         UNIT_HOUR: prod = n3600_ff;
         UNIT_MIN:  prod = n60_ff;
         UNIT_SEC:  prod = {12'h000, num_ff};
         UNIT_NONE: prod = '0;
      endcase
   end

   assign sum       = {1'b0, total_ff} + {1'b0, prod[TB-1:0]};
   assign unit_fail = (unit_code == UNIT_NONE) || (|prod[PW-1:TB]) || sum[TB];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (ev_eos) begin
         phase_in = PH_BETWEEN;
      end else if (ev_char) begin
         unique case (phase_ff)
            PH_BETWEEN: begin
               if (is_digit) phase_in = PH_NUMBER;
            end
            PH_NUMBER, PH_AFTER_NUM: begin
               if (phase_ff == PH_NUMBER && is_digit) phase_in = PH_NUMBER;
               else if (is_blank) phase_in = PH_AFTER_NUM;
               else if (is_alpha) phase_in = PH_UNIT;
            end
            PH_UNIT: begin
               if (!is_alpha && !unit_fail) begin
                  if (is_blank) phase_in = PH_BETWEEN;
                  else if (is_digit) phase_in = PH_NUMBER;
               end
            end
         endcase
      end
   end

   // next accumulators, unit letters and flags
   always_comb begin
      num_in    = num_ff;
      n60_in    = n60_ff;
      n3600_in  = n3600_ff;
      total_in  = total_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      found_in  = found_ff;
      err_in    = err_ff;
      chars_we  = 1'b0;
      chars_idx = len_ff;
      if (ev_eos) begin
         num_in   = '0;
         n60_in   = '0;
         n3600_in = '0;
         total_in = '0;
         len_in   = '0;
         first_in = 1'b1;
         found_in = 1'b0;
         err_in   = 1'b0;
      end else if (ev_char) begin
         unique case (phase_ff)
            PH_BETWEEN: begin
               if (is_digit) begin
                  if (digit_ovf) begin
                     err_in = 1'b1;
                  end else begin
                     num_in   = num_wide[TB-1:0];
                     n60_in   = n60_wide[PW-1:0];
                     n3600_in = n3600_wide[PW-1:0];
                     len_in   = '0;
                  end
               end else if (!is_blank) begin
                  err_in = 1'b1;
               end
            end
            PH_NUMBER, PH_AFTER_NUM: begin
               if (phase_ff == PH_NUMBER && is_digit) begin
                  if (digit_ovf) begin
                     err_in = 1'b1;
                  end else begin
                     num_in   = num_wide[TB-1:0];
                     n60_in   = n60_wide[PW-1:0];
                     n3600_in = n3600_wide[PW-1:0];
                  end
               end else if (is_alpha) begin
                  chars_we  = 1'b1;
                  chars_idx = '0;
                  len_in    = UNIT_LEN_W'(1);
               end else if (!is_blank) begin
                  err_in = 1'b1;
               end
            end
            PH_UNIT: begin
               if (is_alpha) begin
                  if (len_ff == UNIT_LEN_W'(UNIT_DEPTH)) begin
                     err_in = 1'b1;
                  end else begin
                     chars_we = 1'b1;
                     len_in   = len_ff + UNIT_LEN_W'(1);
                  end
               end else if (unit_fail) begin
                  err_in = 1'b1;
               end else begin
                  // close the token, then look at what follows it
                  total_in = sum[TB-1:0];
                  found_in = 1'b1;
                  first_in = 1'b0;
                  len_in   = '0;
                  if (is_digit) begin
                     if (digit_ovf) begin
                        err_in = 1'b1;
                     end else begin
                        num_in   = num_wide[TB-1:0];
                        n60_in   = n60_wide[PW-1:0];
                        n3600_in = n3600_wide[PW-1:0];
                     end
                  end else if (!is_blank) begin
                     err_in = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // result at the end marker: close a pending bare number or unit
   always_comb begin
      bare_end  = (phase_ff == PH_NUMBER) || (phase_ff == PH_AFTER_NUM);
      unit_end  = (phase_ff == PH_UNIT);
      final_err = err_ff || (bare_end && !first_ff) || (unit_end && unit_fail)
                || !(found_ff || bare_end || unit_end);
      if (bare_end) begin
         total_after = num_ff;
      end else if (unit_end) begin
         total_after = sum[TB-1:0];
      end else begin
         total_after = total_ff;
      end
   end

   generate
      if (TB >= SECONDS_W) begin : g_sec_trunc
         assign sec_word = total_after[SECONDS_W-1:0];
      end else begin : g_sec_ext
         assign sec_word = {{(SECONDS_W-TB){1'b0}}, total_after};
      end
   endgenerate

   assign result.done        = ev_eos;
   assign result.rsp.status  = final_err;
   assign result.rsp.seconds = final_err ? '0 : sec_word;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         num_ff   <= '0;
         n60_ff   <= '0;
         n3600_ff <= '0;
         total_ff <= '0;
         len_ff   <= '0;
         first_ff <= 1'b1;
         found_ff <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         n60_ff   <= n60_in;
         n3600_ff <= n3600_in;
         total_ff <= total_in;
         len_ff   <= len_in;
         first_ff <= first_in;
         found_ff <= found_in;
         err_ff   <= err_in;
      end
   end

   // unit letters, lowercased, written at the current length
   always_ff @(posedge clock) begin
      for (int i = 0; i < UNIT_DEPTH; i++) begin
         if (chars_we && chars_idx == UNIT_LEN_W'(i)) begin
            chars_ff[i] <= lower;
         end
      end
   end

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      ev_eos |=> phase_ff == PH_BETWEEN && first_ff && !found_ff && !err_ff)
      else $error("parser state not cleared after end marker");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !ev_eos |=> err_ff)
      else $error("error flag dropped before end marker");

   a_unit_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_UNIT && !err_ff |-> len_ff != '0)
      else $error("unit phase with no stored letter");

endmodule

[hw/rtl/duration_text_parser.sv]
// Top level of the duration text parser: input register, parser, result register.
//
//   channel   ports                                   moves
//   req       req_valid  req_ready  req_data  (in)    one character or end marker per word
//   rsp       rsp_valid  rsp_ready  rsp_data  (out)   status and seconds, one per end marker
//
// One word is taken every cycle unless an end marker is stalled. A word lands in the input
// register; a character is parsed in the next cycle, an end marker once the result slot is
// free, and its result is registered at the end of that cycle. Reset is synchronous and
// returns the parser to the between-tokens state. While a result waits, characters keep
// flowing; an end marker holds in the input register until the result is taken.
module duration_text_parser #(
   parameter int TOTAL_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dtp_pkg::dtp_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dtp_pkg::dtp_rsp_type rsp_data
);
   import dtp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   dtp_req_type    in_word_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   dtp_rsp_type    rsp_word_ff;
   logic           out_free, advance;
   dtp_step_type   step;
   dtp_result_type result;

   // advance a character at once, an end marker only into a free result slot
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_word_ff.end_of_string || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the input word until it advances
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

   assign step.fire = advance;
   assign step.word = in_word_ff;

   dtp_parse_core #(
      .TOTAL_BITS (TOTAL_BITS)
   ) u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.done) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_word_ff <= result.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.done |-> out_free)
      else $error("result produced while result register is occupied");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("stalled input word lost or changed");

   a_eos_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_word_ff.end_of_string && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while end marker stalled");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the duration text parser.
`timescale 1ns / 1ps

module testbench;
   import dtp_pkg::*;

   localparam int          TOTAL_BITS     = 32;
   localparam logic [63:0] TOTAL_MAX      = {64{1'b1}} >> (64 - TOTAL_BITS);
   localparam logic [63:0] HOUR_SECONDS   = 64'd3600;
   localparam logic [63:0] MINUTE_SECONDS = 64'd60;
   localparam logic [63:0] ONE_SECOND     = 64'd1;
   localparam int          STIM_WORDS     = 1050;
   localparam int          DRAIN_EVERY    = 30;
   localparam int          HOLD_OFF       = 400;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic        hold_for_drain;
      dtp_req_type word;
   } feed_entry_type;

   typedef enum logic [1:0] {
      RX_EAGER,
      RX_COIN,
      RX_SPARSE,
      RX_LAZY
   } rx_mode_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   dtp_req_type  req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   dtp_rsp_type  rsp_data;

   // words still to send, and totals awaited from the block
   feed_entry_type feed_q[$];
   dtp_rsp_type    awaited_totals[$];
   bit             drain_next;
   int             words_total;
   int             words_taken;
   int             errors;

   // parser state mirrored for prediction
   dtp_phase_type prs_phase;
   logic [63:0]   prs_number;
   logic [63:0]   prs_total;
   logic [55:0]   prs_unit;
   int            prs_unit_len;
   bit            prs_first;
   bit            prs_found;
   bit            prs_error;

   string UNIT_WORDS[15] = '{"h", "hr", "hrs", "hour", "hours",
                             "m", "min", "mins", "minute", "minutes",
                             "s", "sec", "secs", "second", "seconds"};
   string BAD_UNITS[6]   = '{"hourss", "minutesx", "hs", "x", "mi", "secondsss"};

   duration_text_parser #(
      .TOTAL_BITS(TOTAL_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   // folding in the case bit maps both letter ranges onto the lower one
   function automatic bit is_letter(logic [7:0] c);
      return (c | CASE_BIT) >= CH_LOW_A && (c | CASE_BIT) <= CH_LOW_Z;
   endfunction

   function automatic void clear_parser();
      prs_phase    = PH_BETWEEN;
      prs_number   = '0;
      prs_total    = '0;
      prs_unit     = '0;
      prs_unit_len = 0;
      prs_first    = 1'b1;
      prs_found    = 1'b0;
      prs_error    = 1'b0;
   endfunction

   // seconds per unit of the stored word, zero when unknown
   function automatic logic [63:0] unit_scale(logic [55:0] w);
      case (w)
         56'("h"), 56'("hr"), 56'("hrs"), 56'("hour"), 56'("hours"):
            return HOUR_SECONDS;
         56'("m"), 56'("min"), 56'("mins"), 56'("minute"), 56'("minutes"):
            return MINUTE_SECONDS;
         56'("s"), 56'("sec"), 56'("secs"), 56'("second"), 56'("seconds"):
            return ONE_SECOND;
         default:
            return 64'd0;
      endcase
   endfunction

   function automatic void take_digit(logic [7:0] c);
      logic [63:0] d;
      d = {56'd0, c - CH_ZERO};
      if (prs_number > (TOTAL_MAX - d) / 64'd10) begin
         prs_error = 1'b1;
      end else begin
         prs_number = prs_number * 64'd10 + d;
      end
   endfunction

   function automatic void start_number(logic [7:0] c);
      prs_number   = '0;
      prs_unit_len = 0;
      prs_phase    = PH_NUMBER;
      take_digit(c);
   endfunction

   // add number times unit to the total, flagging unknown units and overflow
   function automatic void close_unit();
      logic [63:0] scale;
      logic [63:0] prod;
      scale = unit_scale(prs_unit);
      if (scale == 0 || prs_number > TOTAL_MAX / scale) begin
         prs_error = 1'b1;
         return;
      end
      prod = prs_number * scale;
      if (prs_total > TOTAL_MAX - prod) begin
         prs_error = 1'b1;
         return;
      end
      prs_total    = prs_total + prod;
      prs_found    = 1'b1;
      prs_first    = 1'b0;
      prs_unit_len = 0;
   endfunction

   // a number without unit stands only as the sole token
   function automatic void close_bare();
      if (!prs_first) begin
         prs_error = 1'b1;
         return;
      end
      prs_total = prs_number;
      prs_found = 1'b1;
   endfunction

   // advance the mirrored parser by one word; an end marker yields a total
   function automatic void advance_parse(dtp_req_type w);
      dtp_rsp_type r;
      if (w.end_of_string) begin
         if (!prs_error) begin
            if (prs_phase == PH_NUMBER || prs_phase == PH_AFTER_NUM) begin
               close_bare();
            end else if (prs_phase == PH_UNIT) begin
               close_unit();
            end
         end
         if (!prs_error && !prs_found) prs_error = 1'b1;
         r.status  = prs_error;
         r.seconds = prs_error ? '0 : prs_total[SECONDS_W-1:0];
         awaited_totals.push_back(r);
         clear_parser();
         return;
      end
      if (prs_error) return;
      case (prs_phase)
         PH_BETWEEN: begin
            if (is_digit(w.ch)) begin
               start_number(w.ch);
            end else if (!is_blank(w.ch)) begin
               prs_error = 1'b1;
            end
         end
         PH_NUMBER, PH_AFTER_NUM: begin
            if (prs_phase == PH_NUMBER && is_digit(w.ch)) begin
               take_digit(w.ch);
            end else if (is_blank(w.ch)) begin
               prs_phase = PH_AFTER_NUM;
            end else if (is_letter(w.ch)) begin
               prs_unit     = {48'd0, w.ch | CASE_BIT};
               prs_unit_len = 1;
               prs_phase    = PH_UNIT;
            end else begin
               prs_error = 1'b1;
            end
         end
         default: begin
            if (is_letter(w.ch)) begin
               if (prs_unit_len >= UNIT_DEPTH) begin
                  prs_error = 1'b1;
               end else begin
                  prs_unit     = {prs_unit[47:0], w.ch | CASE_BIT};
                  prs_unit_len = prs_unit_len + 1;
               end
            end else begin
               close_unit();
               if (!prs_error) begin
                  if (is_blank(w.ch)) begin
                     prs_phase = PH_BETWEEN;
                  end else if (is_digit(w.ch)) begin
                     start_number(w.ch);
                  end else begin
                     prs_error = 1'b1;
                  end
               end
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus construction
   // ------------------------------------------------------------------

   function automatic void put_word(logic [7:0] c, logic eos);
      feed_entry_type e;
      e.word.ch            = c;
      e.word.end_of_string = eos;
      e.hold_for_drain     = drain_next;
      drain_next           = 1'b0;
      feed_q.push_back(e);
   endfunction

   // mixed case raises lower-case letters at random
   function automatic void put_text(string s, bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(1) == 1) begin
            c = c & ~CASE_BIT;
         end
         put_word(c, 1'b0);
      end
   endfunction

   function automatic void put_blanks(int n);
      repeat (n) put_word($urandom_range(1) == 1 ? CH_SPACE : CH_TAB, 1'b0);
   endfunction

   function automatic string random_number();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return $sformatf("%0d", $urandom_range(999));
      if (pick < 8) return $sformatf("%0d", $urandom);
      if (pick == 8) return $sformatf("0%0d", $urandom_range(99));
      return $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
   endfunction

   // mostly well-formed token lists, with some bare numbers, noise and broken units
   function automatic void put_random_string();
      int kind;
      int tokens;
      kind = $urandom_range(99);
      if (kind < 10) begin
         put_blanks($urandom_range(2));
         put_text(random_number(), 1'b0);
         put_blanks($urandom_range(2));
      end else if (kind < 22) begin
         repeat ($urandom_range(8)) put_word($urandom_range(255), 1'b0);
      end else begin
         tokens = $urandom_range(1, 4);
         if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
         for (int k = 0; k < tokens; k++) begin
            put_text(random_number(), 1'b0);
            if ($urandom_range(1) == 1) put_blanks($urandom_range(1, 2));
            if (kind < 32 && k == tokens - 1) begin
               // break the last token
               if ($urandom_range(1) == 1) begin
                  put_text(BAD_UNITS[$urandom_range(5)], 1'b1);
               end else begin
                  put_text(UNIT_WORDS[$urandom_range(14)], 1'b1);
                  put_word($urandom_range(255), 1'b0);
               end
            end else begin
               put_text(UNIT_WORDS[$urandom_range(14)], 1'b1);
            end
            if (k < tokens - 1 ? $urandom_range(1) == 1 : $urandom_range(3) == 0) begin
               put_blanks($urandom_range(1, 2));
            end
         end
      end
      put_word($urandom_range(255), 1'b1);
   endfunction

   // ------------------------------------------------------------------
   // driver: bursts of words with random gaps, optional drain pauses
   // ------------------------------------------------------------------

   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      feed_entry_type entry;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_parse(req_data);
            words_taken = words_taken + 1;
         end
         if (req_valid && !req_ready) begin
            // hold the word until it is taken
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (feed_q.size() != 0 &&
                      !(feed_q[0].hold_for_drain && awaited_totals.size() != 0)) begin
            entry = feed_q.pop_front();
            req_valid <= 1'b1;
            req_data  <= entry.word;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall pattern of its own, with two long hold-offs
   // ------------------------------------------------------------------

   rx_mode_type rx_mode  = RX_EAGER;
   int          rx_span  = 0;
   int          rx_tick  = 0;
   int          rx_count = 0;
   int          hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rx_count = rx_count + 1;
            if (rx_count == 15 || rx_count == 70) hold_left = HOLD_OFF;
         end
         if (rx_span == 0) begin
            rx_mode = rx_mode_type'($urandom_range(3));
            rx_span = $urandom_range(20, 120);
         end
         rx_span = rx_span - 1;
         rx_tick = rx_tick + 1;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_EAGER:  rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= $urandom_range(1) == 1;
               RX_SPARSE: rsp_ready <= (rx_tick % 4) == 0;
               default:   rsp_ready <= $urandom_range(7) != 0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: compare each taken result with the oldest awaited total
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      dtp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_totals.size() == 0) begin
            $display("%0t: unexpected result: expected none, got status %0d seconds %0d",
                     $time, rsp_data.status, rsp_data.seconds);
            errors = errors + 1;
         end else begin
            want = awaited_totals.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               errors = errors + 1;
            end
            if (rsp_data.seconds !== want.seconds) begin
               $display("%0t: seconds mismatch: expected %0d, got %0d",
                        $time, want.seconds, rsp_data.seconds);
               errors = errors + 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: end the run when nothing moves for too long
   // ------------------------------------------------------------------

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d totals still awaited",
                     $time, idle_cycles, awaited_totals.size());
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus, reset and verdict
   // ------------------------------------------------------------------

   initial begin
      int strings_built;
      strings_built = 0;
      words_taken   = 0;
      errors        = 0;
      drain_next    = 1'b0;
      clear_parser();

      // empty and blank strings
      put_word($urandom_range(255), 1'b1);
      put_text(" \t ", 1'b0);
      put_word($urandom_range(255), 1'b1);
      // bare numbers, with padding, at the limit and just over it; a number with unit over it
      put_text("42", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("  007 \t", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("4294967295", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("4294967296", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("99999999999s", 1'b0);
      put_word($urandom_range(255), 1'b1);
      // every unit spelling, glued and spaced, in mixed case
      put_text("1h2m3s", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("1hours 2 MINUTES\t3Seconds", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("4hr 5Hrs 6hour", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("7min 8mins 9minute 10 minutes", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("11sec 12secs 13second 14seconds", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("0s", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("5 h ", 1'b0);
      put_word($urandom_range(255), 1'b1);
      // product at the limit, product over it, total over it
      put_text("1193046h", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("1193047h", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("4294967295s 1s", 1'b0);
      put_word($urandom_range(255), 1'b1);
      // bare number after a unit, unknown unit, overlong unit, stray characters
      put_text("1h 5", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("3 x", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("1minutess", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("1h#2m", 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_word(8'h00, 1'b0);
      put_word($urandom_range(255), 1'b1);
      put_text("1h", 1'b0);
      put_word(8'hff, 1'b0);
      put_word($urandom_range(255), 1'b1);

      // random strings, pausing now and then until every total is back
      while (feed_q.size() < STIM_WORDS) begin
         if (strings_built % DRAIN_EVERY == DRAIN_EVERY - 1) drain_next = 1'b1;
         put_random_string();
         strings_built = strings_built + 1;
      end
      words_total = feed_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < words_total || awaited_totals.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/dtp_pkg.sv
hw/rtl/dtp_unit_match.sv
hw/rtl/dtp_parse_core.sv
hw/rtl/duration_text_parser.sv
tb/testbench.sv
